>>> hw/rtl/json_token_lexer_macros.svh
// ----------------------------------------------------------------------------
// JSON token lexer assertion macros
// Concurrent assertion helpers clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef JSON_TOKEN_LEXER_MACROS_SVH
`define JSON_TOKEN_LEXER_MACROS_SVH

`ifndef NO_ASSERTIONS

`define JTL_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define JTL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define JTL_ASSERT_SAME(label, ante, cons, msg)

`define JTL_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

>>> hw/rtl/jtl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON token lexer package
// Widths, token kind codes, lexer modes, character codes and small helpers.
// ----------------------------------------------------------------------------
package jtl_pkg;

    localparam int OFFSET_BITS = 32;
    localparam logic [OFFSET_BITS-1:0] POS_MAX = '1;
    localparam int MAX_TOKENS = 5;
    localparam int ERR_SLOTS = 4;

    localparam logic [3:0] KIND_COLON         = 4'd0;
    localparam logic [3:0] KIND_COMMA         = 4'd1;
    localparam logic [3:0] KIND_OPEN_BRACE    = 4'd2;
    localparam logic [3:0] KIND_CLOSE_BRACE   = 4'd3;
    localparam logic [3:0] KIND_OPEN_BRACKET  = 4'd4;
    localparam logic [3:0] KIND_CLOSE_BRACKET = 4'd5;
    localparam logic [3:0] KIND_STRING        = 4'd6;
    localparam logic [3:0] KIND_NUMBER        = 4'd7;
    localparam logic [3:0] KIND_TRUE          = 4'd8;
    localparam logic [3:0] KIND_FALSE         = 4'd9;
    localparam logic [3:0] KIND_ERROR         = 4'd10;

    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_LBRACE  = 8'h7B;
    localparam logic [7:0] CH_RBRACE  = 8'h7D;
    localparam logic [7:0] CH_LBRACK  = 8'h5B;
    localparam logic [7:0] CH_RBRACK  = 8'h5D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_T       = 8'h74;
    localparam logic [7:0] CH_R       = 8'h72;
    localparam logic [7:0] CH_U       = 8'h75;
    localparam logic [7:0] CH_E       = 8'h65;
    localparam logic [7:0] CH_F       = 8'h66;
    localparam logic [7:0] CH_A       = 8'h61;
    localparam logic [7:0] CH_L       = 8'h6C;
    localparam logic [7:0] CH_S       = 8'h73;

    localparam logic [2:0] TRUE_LEN  = 3'd4;
    localparam logic [2:0] FALSE_LEN = 3'd5;

    typedef enum logic [5:0] {
        MODE_IDLE  = 6'b000001,
        MODE_STR   = 6'b000010,
        MODE_INT   = 6'b000100,
        MODE_FRAC  = 6'b001000,
        MODE_TRUE  = 6'b010000,
        MODE_FALSE = 6'b100000
    } lex_mode_t;

    typedef struct packed {
        logic [3:0]             kind;
        logic [OFFSET_BITS-1:0] start;
        logic [OFFSET_BITS-1:0] len;
        logic [31:0]            line;
    } token_t;

    function automatic logic [OFFSET_BITS-1:0] pos_inc(input logic [OFFSET_BITS-1:0] a);
        pos_inc = (a == POS_MAX) ? a : a + 1'b1;
    endfunction

    // Saturating add of a small offset (0 to 3) to a position.
    function automatic logic [OFFSET_BITS-1:0] pos_add_small(
        input logic [OFFSET_BITS-1:0] a,
        input logic [1:0]             i
    );
        logic [OFFSET_BITS:0] sum;
        sum = {1'b0, a} + (OFFSET_BITS + 1)'(i);
        pos_add_small = sum[OFFSET_BITS] ? POS_MAX : sum[OFFSET_BITS-1:0];
    endfunction

    function automatic logic [OFFSET_BITS-1:0] pos_span(
        input logic [OFFSET_BITS-1:0] from,
        input logic [OFFSET_BITS-1:0] to
    );
        pos_span = (to >= from) ? to - from : '0;
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
    endfunction

    // Expected byte at position idx of the word true or false.
    function automatic logic [7:0] literal_byte(input logic is_true, input logic [2:0] idx);
        literal_byte = 8'h00;
        if (is_true)
        begin
            case (idx)
                3'd0:    literal_byte = CH_T;
                3'd1:    literal_byte = CH_R;
                3'd2:    literal_byte = CH_U;
                3'd3:    literal_byte = CH_E;
                default: literal_byte = 8'h00;
            endcase
        end
        else
        begin
            case (idx)
                3'd0:    literal_byte = CH_F;
                3'd1:    literal_byte = CH_A;
                3'd2:    literal_byte = CH_L;
                3'd3:    literal_byte = CH_S;
                3'd4:    literal_byte = CH_E;
                default: literal_byte = 8'h00;
            endcase
        end
    endfunction

endpackage

>>> hw/rtl/jtl_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON token lexer input channel
// Valid/ready channel carrying one document byte or an end marker.
// ----------------------------------------------------------------------------
interface jtl_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_document;

    modport source (output valid, output data_byte, output end_of_document, input ready);
    modport sink   (input valid, input data_byte, input end_of_document, output ready);
endinterface

>>> hw/rtl/jtl_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON token lexer output channel
// Valid/ready channel carrying one token per transfer.
// ----------------------------------------------------------------------------
interface jtl_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  token_kind;
    logic [31:0] start_offset;
    logic [31:0] token_length;
    logic [31:0] line_index;
    logic        last_of_run;

    modport source (output valid, output token_kind, output start_offset,
                    output token_length, output line_index, output last_of_run,
                    input ready);
    modport sink   (input valid, input token_kind, input start_offset,
                    input token_length, input line_index, input last_of_run,
                    output ready);
endinterface

>>> hw/rtl/json_token_lexer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON token lexer
// Streaming lexer for simplified JSON: punctuation, strings, numbers,
// true, false and one-byte error tokens, with byte offsets and line numbers.
// ----------------------------------------------------------------------------
// The lexer takes one byte per clock cycle unless tokens of an earlier byte
// are still waiting. Each accepted byte is lexed in the same cycle against the
// mode and counter registers, and the tokens it causes (zero to five) are
// loaded into a result register that drains one token per transfer on the
// output side. A byte that yields several tokens holds the input until all of
// them have been transferred. A new byte is taken in the same cycle in which
// the last token of the previous byte is transferred.
// While tokens of one byte are still waiting, the next byte is held off,
// whether or not it would yield a token itself.
// There is no start-up sequence after reset.
module json_token_lexer
    import jtl_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    jtl_in_if.sink  in_bus,
    jtl_out_if.source out_bus
);

`include "json_token_lexer_macros.svh"

    lex_mode_t              lex_mode_reg, lex_mode_next;
    logic [2:0]             literal_matched_reg, literal_matched_next;
    logic [OFFSET_BITS-1:0] byte_position_reg, byte_position_next;
    logic [OFFSET_BITS-1:0] token_start_reg, token_start_next;
    logic [31:0]            token_line_reg, token_line_next;
    logic [31:0]            line_count_reg, line_count_next;

    token_t                 run_tok_reg [MAX_TOKENS];
    logic [2:0]             run_last_reg;
    logic [2:0]             run_idx_reg;
    logic                   run_valid_reg;

    logic                   in_fire;
    logic                   out_fire;
    logic                   out_is_last;

    token_t                 lead_tok;
    logic                   lead_valid;
    token_t                 tail_tok;
    logic                   tail_valid;
    token_t                 err_tok [ERR_SLOTS];
    logic [2:0]             err_cnt;
    logic                   do_idle;
    logic                   lit_is_true;
    logic [2:0]             lit_len;
    token_t                 slot_tok [MAX_TOKENS];
    logic [2:0]             tok_cnt;
    token_t                 cur_tok;

    assign out_is_last  = (run_idx_reg == run_last_reg);
    assign in_bus.ready = !run_valid_reg || (out_bus.ready && out_is_last);
    assign in_fire      = in_bus.valid && in_bus.ready;
    assign out_fire     = out_bus.valid && out_bus.ready;

    assign lit_is_true = (lex_mode_reg == MODE_TRUE);
    assign lit_len     = lit_is_true ? TRUE_LEN : FALSE_LEN;

    always_comb
    begin
        lex_mode_next        = lex_mode_reg;
        literal_matched_next = literal_matched_reg;
        byte_position_next   = byte_position_reg;
        token_start_next     = token_start_reg;
        token_line_next      = token_line_reg;
        line_count_next      = line_count_reg;
        lead_valid           = 1'b0;
        lead_tok             = '0;
        tail_valid           = 1'b0;
        tail_tok             = '0;
        err_cnt              = 3'd0;
        do_idle              = 1'b0;

        if (in_bus.end_of_document)
        begin
            case (lex_mode_reg)
                MODE_STR:
                begin
                    lead_valid = 1'b1;
                    lead_tok   = '{KIND_STRING, token_start_reg,
                                   pos_span(token_start_reg, byte_position_reg),
                                   token_line_reg};
                end
                MODE_INT, MODE_FRAC:
                begin
                    lead_valid = 1'b1;
                    lead_tok   = '{KIND_NUMBER, token_start_reg,
                                   pos_span(token_start_reg, byte_position_reg),
                                   token_line_reg};
                end
                MODE_TRUE, MODE_FALSE:
                begin
                    err_cnt = (literal_matched_reg > 3'd4) ? 3'd4 : literal_matched_reg;
                end
                default:
                begin
                end
            endcase
            lex_mode_next        = MODE_IDLE;
            literal_matched_next = 3'd0;
            byte_position_next   = '0;
            token_start_next     = '0;
            token_line_next      = '0;
            line_count_next      = '0;
        end
        else
        begin
            case (lex_mode_reg)
                MODE_STR:
                begin
                    if (in_bus.data_byte == CH_QUOTE)
                    begin
                        lead_valid    = 1'b1;
                        lead_tok      = '{KIND_STRING, token_start_reg,
                                          pos_span(token_start_reg, byte_position_reg),
                                          token_line_reg};
                        lex_mode_next = MODE_IDLE;
                    end
                end
                MODE_INT, MODE_FRAC:
                begin
                    if (is_digit(in_bus.data_byte))
                    begin
                        lex_mode_next = lex_mode_reg;
                    end
                    else if (in_bus.data_byte == CH_DOT && lex_mode_reg == MODE_INT)
                    begin
                        lex_mode_next = MODE_FRAC;
                    end
                    else
                    begin
                        lead_valid           = 1'b1;
                        lead_tok             = '{KIND_NUMBER, token_start_reg,
                                                 pos_span(token_start_reg, byte_position_reg),
                                                 token_line_reg};
                        lex_mode_next        = MODE_IDLE;
                        literal_matched_next = 3'd0;
                        do_idle              = 1'b1;
                    end
                end
                MODE_TRUE, MODE_FALSE:
                begin
                    if (literal_matched_reg < lit_len &&
                        in_bus.data_byte == literal_byte(lit_is_true, literal_matched_reg))
                    begin
                        literal_matched_next = literal_matched_reg + 3'd1;
                        if (literal_matched_reg + 3'd1 == lit_len)
                        begin
                            lead_valid           = 1'b1;
                            lead_tok             = '{lit_is_true ? KIND_TRUE : KIND_FALSE,
                                                     token_start_reg,
                                                     OFFSET_BITS'(lit_len),
                                                     token_line_reg};
                            lex_mode_next        = MODE_IDLE;
                            literal_matched_next = 3'd0;
                        end
                    end
                    else
                    begin
                        // Every byte held so far becomes an error token.
                        err_cnt              = (literal_matched_reg > 3'd4) ? 3'd4
                                                                            : literal_matched_reg;
                        lex_mode_next        = MODE_IDLE;
                        literal_matched_next = 3'd0;
                        do_idle              = 1'b1;
                    end
                end
                MODE_IDLE:
                begin
                    do_idle = 1'b1;
                end
                default:
                begin
                    lex_mode_next        = MODE_IDLE;
                    literal_matched_next = 3'd0;
                    do_idle              = 1'b1;
                end
            endcase

            byte_position_next = pos_inc(byte_position_reg);

            if (do_idle)
            begin
                tail_tok = '{KIND_ERROR, byte_position_reg, OFFSET_BITS'(1), line_count_reg};
                case (in_bus.data_byte)
                    CH_COLON:
                    begin
                        tail_valid    = 1'b1;
                        tail_tok.kind = KIND_COLON;
                    end
                    CH_COMMA:
                    begin
                        tail_valid    = 1'b1;
                        tail_tok.kind = KIND_COMMA;
                    end
                    CH_LBRACE:
                    begin
                        tail_valid    = 1'b1;
                        tail_tok.kind = KIND_OPEN_BRACE;
                    end
                    CH_RBRACE:
                    begin
                        tail_valid    = 1'b1;
                        tail_tok.kind = KIND_CLOSE_BRACE;
                    end
                    CH_LBRACK:
                    begin
                        tail_valid    = 1'b1;
                        tail_tok.kind = KIND_OPEN_BRACKET;
                    end
                    CH_RBRACK:
                    begin
                        tail_valid    = 1'b1;
                        tail_tok.kind = KIND_CLOSE_BRACKET;
                    end
                    CH_SPACE, CH_TAB, CH_CR:
                    begin
                    end
                    CH_LF:
                    begin
                        line_count_next = (line_count_reg == '1) ? line_count_reg
                                                                  : line_count_reg + 32'd1;
                    end
                    CH_QUOTE:
                    begin
                        lex_mode_next    = MODE_STR;
                        token_start_next = pos_inc(byte_position_reg);
                        token_line_next  = line_count_reg;
                    end
                    CH_T, CH_F:
                    begin
                        lex_mode_next        = (in_bus.data_byte == CH_T) ? MODE_TRUE
                                                                          : MODE_FALSE;
                        literal_matched_next = 3'd1;
                        token_start_next     = byte_position_reg;
                        token_line_next      = line_count_reg;
                    end
                    default:
                    begin
                        if (in_bus.data_byte inside {CH_MINUS, [CH_ZERO:CH_NINE]})
                        begin
                            lex_mode_next    = MODE_INT;
                            token_start_next = byte_position_reg;
                            token_line_next  = line_count_reg;
                        end
                        else
                        begin
                            tail_valid = 1'b1;
                        end
                    end
                endcase
            end
        end
    end

    // Error tokens of a broken or unfinished literal, one per held byte.
    always_comb
    begin
        for (int i = 0; i < ERR_SLOTS; i++)
        begin
            err_tok[i] = '{KIND_ERROR, pos_add_small(token_start_reg, 2'(i)),
                           OFFSET_BITS'(1), token_line_reg};
        end
    end

    // A run is a leading token, a group of error tokens or neither, then an
    // optional token lexed from the same byte in idle mode.
    always_comb
    begin
        for (int s = 0; s < MAX_TOKENS; s++)
        begin
            if (lead_valid)
            begin
                slot_tok[s] = (s == 0) ? lead_tok : tail_tok;
            end
            else if (s < ERR_SLOTS && 3'(s) < err_cnt)
            begin
                slot_tok[s] = err_tok[s % ERR_SLOTS];
            end
            else
            begin
                slot_tok[s] = tail_tok;
            end
        end
        tok_cnt = (lead_valid ? 3'd1 : err_cnt) + {2'b00, tail_valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lex_mode_reg        <= MODE_IDLE;
            literal_matched_reg <= 3'd0;
            byte_position_reg   <= '0;
            token_start_reg     <= '0;
            token_line_reg      <= '0;
            line_count_reg      <= '0;
            run_valid_reg       <= 1'b0;
            run_idx_reg         <= 3'd0;
            run_last_reg        <= 3'd0;
        end
        else
        begin
            if (in_fire)
            begin
                lex_mode_reg        <= lex_mode_next;
                literal_matched_reg <= literal_matched_next;
                byte_position_reg   <= byte_position_next;
                token_start_reg     <= token_start_next;
                token_line_reg      <= token_line_next;
                line_count_reg      <= line_count_next;
            end

            if (in_fire && tok_cnt != 3'd0)
            begin
                run_valid_reg <= 1'b1;
                run_idx_reg   <= 3'd0;
                run_last_reg  <= tok_cnt - 3'd1;
            end
            else if (out_fire)
            begin
                if (out_is_last)
                begin
                    run_valid_reg <= 1'b0;
                end
                else
                begin
                    run_idx_reg <= run_idx_reg + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && tok_cnt != 3'd0)
        begin
            for (int s = 0; s < MAX_TOKENS; s++)
            begin
                run_tok_reg[s] <= slot_tok[s];
            end
        end
    end

    always_comb
    begin
        cur_tok = run_tok_reg[0];
        for (int s = 0; s < MAX_TOKENS; s++)
        begin
            if (run_idx_reg == 3'(s))
            begin
                cur_tok = run_tok_reg[s];
            end
        end
    end

    assign out_bus.valid        = run_valid_reg;
    assign out_bus.token_kind   = cur_tok.kind;
    assign out_bus.start_offset = 32'(cur_tok.start);
    assign out_bus.token_length = 32'(cur_tok.len);
    assign out_bus.line_index   = cur_tok.line;
    assign out_bus.last_of_run  = out_is_last;

    `JTL_ASSERT_SAME(a_idx_in_run, run_valid_reg, run_idx_reg <= run_last_reg, "token index past end of run")
    `JTL_ASSERT_SAME(a_run_bound, run_valid_reg, run_last_reg < 3'(MAX_TOKENS), "run longer than five tokens")
    `JTL_ASSERT_NEXT(a_end_resets, in_fire && in_bus.end_of_document, byte_position_reg == '0 && lex_mode_reg == MODE_IDLE && line_count_reg == '0, "end of document did not reset counters")
    `JTL_ASSERT_SAME(a_literal_count, literal_matched_reg != 3'd0, lex_mode_reg == MODE_TRUE || lex_mode_reg == MODE_FALSE, "literal bytes held outside a literal")

endmodule
